[design/hce_pkg.sv]
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types, constants and helpers for the HTTP chunked transfer encoder.
// ----------------------------------------------------------------------------
package hce_pkg;

	localparam int unsigned FRAME_BYTES = 9;   // header 6 + payload 1 + trailer 2
	localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

	localparam logic [15:0] MAX_CHUNK_RST = 16'h8000;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// input kinds carried on s_tuser
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	// bytes owed for one accepted item, first byte in bytes[0]
	typedef struct packed {
		logic [FRAME_BYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]            cnt;
		logic                        eos;
	} frame_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};   // 'a' - 10
		end
		return c;
	endfunction

endpackage

[design/hce_frame.sv]
// ----------------------------------------------------------------------------
// hce_frame
// Decodes one input item against the chunk state into the bytes it produces.
// ----------------------------------------------------------------------------
module hce_frame (
	input  logic                 cmd,
	input  logic [7:0]           data_byte,
	input  logic [15:0]          available,
	input  logic [15:0]          max_chunk,
	input  logic [15:0]          remaining,
	input  logic                 finished,
	output hce_pkg::frame_t      frame,
	output logic                 emit,
	output logic [15:0]          remaining_next,
	output logic                 finished_next
);

	logic [15:0] avail_c;
	logic [15:0] cap_c;
	logic [15:0] len;
	logic [15:0] rem_dec;
	logic        open;
	logic        trailer;

	always_comb begin
		avail_c = (available == 16'd0) ? 16'd1 : available;
		cap_c   = (max_chunk == 16'd0) ? 16'd1 : max_chunk;
		len     = (avail_c > cap_c) ? cap_c : avail_c;
		open    = (remaining != 16'd0);
		rem_dec = (open ? remaining : len) - 16'd1;
		trailer = (rem_dec == 16'd0);
	end

	always_comb begin
		frame          = '0;
		emit           = 1'b0;
		remaining_next = remaining;
		finished_next  = finished;
		if (!finished) begin
			if (cmd == hce_pkg::CMD_EOS) begin
				// end of stream is ignored while a chunk is open
				if (!open) begin
					emit           = 1'b1;
					finished_next  = 1'b1;
					frame.eos      = 1'b1;
					frame.bytes[0] = hce_pkg::CH_ZERO;
					frame.bytes[1] = hce_pkg::CH_CR;
					frame.bytes[2] = hce_pkg::CH_LF;
					frame.bytes[3] = hce_pkg::CH_CR;
					frame.bytes[4] = hce_pkg::CH_LF;
					frame.cnt      = hce_pkg::IDX_W'(5);
				end
			end else begin
				emit           = 1'b1;
				remaining_next = rem_dec;
				if (open) begin
					frame.bytes[0] = data_byte;
					frame.bytes[1] = hce_pkg::CH_CR;
					frame.bytes[2] = hce_pkg::CH_LF;
					frame.cnt      = trailer ? hce_pkg::IDX_W'(3) : hce_pkg::IDX_W'(1);
				end else begin
					frame.bytes[0] = hce_pkg::hex_char(len[15:12]);
					frame.bytes[1] = hce_pkg::hex_char(len[11:8]);
					frame.bytes[2] = hce_pkg::hex_char(len[7:4]);
					frame.bytes[3] = hce_pkg::hex_char(len[3:0]);
					frame.bytes[4] = hce_pkg::CH_CR;
					frame.bytes[5] = hce_pkg::CH_LF;
					frame.bytes[6] = data_byte;
					frame.bytes[7] = hce_pkg::CH_CR;
					frame.bytes[8] = hce_pkg::CH_LF;
					frame.cnt      = trailer ? hce_pkg::IDX_W'(9) : hce_pkg::IDX_W'(7);
				end
			end
		end
	end

endmodule

[design/hce_emit.sv]
// ----------------------------------------------------------------------------
// hce_emit
// Holds one decoded frame and serializes it into the output byte register.
// ----------------------------------------------------------------------------
module hce_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  hce_pkg::frame_t frame_in,
	output logic            free,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            out_last,
	output logic            out_done,
	input  logic            out_ready
);

	hce_pkg::frame_t              frame_s1;
	logic                         valid_s1;
	logic [hce_pkg::IDX_W-1:0]    idx_q;
	logic [7:0]                   byte_s2;
	logic                         valid_s2;
	logic                         last_s2;
	logic                         done_s2;

	logic adv2;
	logic move;
	logic at_end;

	assign adv2   = !valid_s2 || out_ready;
	assign move   = valid_s1 && adv2;
	assign at_end = (idx_q == frame_s1.cnt - hce_pkg::IDX_W'(1));
	assign free   = !valid_s1 || (adv2 && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (move) begin
				idx_q <= at_end ? '0 : idx_q + hce_pkg::IDX_W'(1);
				if (at_end) begin
					valid_s1 <= 1'b0;
				end
			end
			if (load) begin
				valid_s1 <= 1'b1;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_s1 <= frame_in;
		end
		if (move) begin
			byte_s2 <= frame_s1.bytes[idx_q];
			last_s2 <= at_end;
			done_s2 <= at_end && frame_s1.eos;
		end
	end

	assign out_byte  = byte_s2;
	assign out_valid = valid_s2;
	assign out_last  = last_s2;
	assign out_done  = done_s2;

endmodule

[design/http_chunked_encoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_encoder
// Frames a byte stream as HTTP/1.1 chunked transfer coding.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / data             | tuser        | tlast
//  s_axis   | in        | [7:0] data_byte,          | cmd          | -
//           |           | [23:8] available          |              |
//  m_axis   | out       | [7:0] out_byte            | stream_done  | last of item
//  cfg      | in        | [15:0] max_chunk          | -            | -
//
// An item that opens no chunk and closes none produces one byte; a chunk
// opener produces 7 or 9 bytes, a closing byte 3, end of stream 5; the
// output byte port moves one byte per cycle unless stalled. Chunk state
// updates on the input transfer; items that produce nothing load no frame.
// Reset puts max_chunk to 0x8000 with no chunk open. A stalled output holds
// one byte in the output register and one frame behind it.
// ----------------------------------------------------------------------------
module http_chunked_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] available
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser,   // stream_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // max_chunk
);

	logic [15:0]     max_chunk_q;
	logic [15:0]     remaining_q;
	logic            finished_q;

	hce_pkg::frame_t frame;
	logic            emit;
	logic [15:0]     remaining_next;
	logic            finished_next;
	logic            free;
	logic            accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = free;
	assign accept    = s_tvalid && s_tready;

	hce_frame u_frame (
		.cmd            (s_tuser),
		.data_byte      (s_tdata[7:0]),
		.available      (s_tdata[23:8]),
		.max_chunk      (max_chunk_q),
		.remaining      (remaining_q),
		.finished       (finished_q),
		.frame          (frame),
		.emit           (emit),
		.remaining_next (remaining_next),
		.finished_next  (finished_next)
	);

	hce_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && emit),
		.frame_in  (frame),
		.free      (free),
		.out_byte  (m_tdata),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_done  (m_tuser),
		.out_ready (m_tready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= hce_pkg::MAX_CHUNK_RST;
			remaining_q <= '0;
			finished_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_chunk_q <= cfg_data;
			end
			if (accept) begin
				remaining_q <= remaining_next;
				finished_q  <= finished_next;
			end
		end
	end

	// stream_done only ever rides on the closing byte of an item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("stream_done without tlast");

	// the terminating chunk is only sent once the stream is marked finished
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> finished_q)
		else $error("stream_done before finish");

	// once finished, accepted items leave the chunk count alone
	a_frozen_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		accept && finished_q |=> $stable(remaining_q) && finished_q)
		else $error("state changed after finish");

endmodule
